FILE: hdl/modular_power_inverse_divide_core_macros.svh
// assertion macros for the modular power / inverse / divide core
// included by the modules that carry concurrent checks; no other dependencies
`ifndef MODULAR_POWER_INVERSE_DIVIDE_CORE_MACROS_SVH
`define MODULAR_POWER_INVERSE_DIVIDE_CORE_MACROS_SVH

`ifndef SYNTH
// plain property checked on every clock edge outside reset
`define MPID_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// antecedent in this cycle, consequent in the next
`define MPID_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MPID_ASSERT(lbl, clk, rstn, prop, msg)
`define MPID_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

FILE: hdl/mpid_pkg.sv
// shared widths, request codes and the remainder step of the modular core
// no dependencies
package mpid_pkg;

  localparam int unsigned ModW    = 32;
  localparam int unsigned OpW     = 63;
  localparam int unsigned ReqW    = 2;
  localparam int unsigned ProdW   = 2 * ModW;
  localparam int unsigned PAddrW  = 3;
  // two dividend bits are retired per cycle
  localparam int unsigned RedSteps = ProdW / 2;
  localparam int unsigned CntW     = $clog2(RedSteps);

  localparam logic [ModW-1:0] ModulusReset = 32'd1000000007;

  localparam logic [ReqW-1:0] ReqPower   = 2'd0;
  localparam logic [ReqW-1:0] ReqInverse = 2'd1;
  localparam logic [ReqW-1:0] ReqDivide  = 2'd2;

  localparam logic [PAddrW-3:0] RegModulus = '0;

  // one restoring step: shift in a bit, subtract m once if it fits
  function automatic logic [ModW-1:0] red_step(input logic [ModW-1:0] rem,
                                                input logic            bit_in,
                                                input logic [ModW-1:0] m);
    logic [ModW:0] t;
    t = {rem, bit_in};
    if (t >= {1'b0, m}) begin
      t = t - {1'b0, m};
    end
    return t[ModW-1:0];
  endfunction

endpackage

FILE: hdl/modular_power_inverse_divide_core.sv
// modular power / inverse / divide core, top level
// depends on mpid_pkg and modular_power_inverse_divide_core_macros.svh
//
// usage:
//   config: APB-style port, one 32-bit register (modulus) at byte address 0,
//   reset value 1000000007; write it only while the core is idle.
//   input channel: req_type_i, operand_a_i, operand_b_i with in_valid_i and
//   in_stall_o; a word is taken when valid is high and stall is low. stall is
//   high from acceptance until the result has moved to the output register.
//   output channel: result_o with out_valid_o and out_stall_i; the output
//   register holds the result until the receiver takes it, and the core takes
//   the next request meanwhile. a finished result waits internally while the
//   output register is still full.
//   datapath: one shared 32x32 multiplier and a 2-bit-per-cycle remainder unit
//   do all the work. each operand is reduced on its own; each exponent bit
//   costs a square, plus a multiply when the bit is set, and each multiply
//   is followed by a full reduction. a modulus below 2 or an undefined code
//   returns 0 without any reduction.
//   reset: asynchronous, active low; the core comes up idle with the modulus
//   at its reset value and no result pending.
module modular_power_inverse_divide_core
  import mpid_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PAddrW-1:0] paddr,
  input  logic [ModW-1:0]   pwdata,
  output logic [ModW-1:0]   prdata,
  output logic              pready,
  // request channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [ReqW-1:0]   req_type_i,
  input  logic [OpW-1:0]    operand_a_i,
  input  logic [OpW-1:0]    operand_b_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ModW-1:0]   result_o
);

  `include "modular_power_inverse_divide_core_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED_A,
    S_RED_B,
    S_POW_CHK,
    S_MUL,
    S_RED,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    STEP_ACC,
    STEP_SQR,
    STEP_FIN
  } step_e;

  state_e            state_q, state_d;
  step_e             step_q, step_d;
  logic              out_valid_q, out_valid_d;
  logic [ModW-1:0]   result_q, result_d;
  logic [ModW-1:0]   modulus_q;
  logic [ReqW-1:0]   req_q, req_d;
  logic [OpW-1:0]    exp_q, exp_d;
  logic [ModW-1:0]   base_q, base_d;
  logic [ModW-1:0]   acc_q, acc_d;
  logic [ModW-1:0]   ared_q, ared_d;
  logic [ProdW-1:0]  div_q, div_d;
  logic [ModW-1:0]   rem_q, rem_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  logic              cfg_wr;
  logic [ModW-1:0]   rem_mid, rem_nxt;
  logic              red_last;
  logic [ModW-1:0]   mul_x, mul_y;
  logic [ProdW-1:0]  prod;
  logic [OpW-1:0]    exp_m2;
  logic              in_accept;

  // ---------------------------------------------------------------------------
  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[PAddrW-1:2] == RegModulus);
  assign prdata = (paddr[PAddrW-1:2] == RegModulus) ? modulus_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= ModulusReset;
    end else if (cfg_wr) begin
      modulus_q <= pwdata;
    end
  end

  // ---------------------------------------------------------------------------
  // shared datapath: remainder unit and multiplier
  always_comb begin
    rem_mid = red_step(rem_q, div_q[ProdW-1], modulus_q);
    rem_nxt = red_step(rem_mid, div_q[ProdW-2], modulus_q);
  end

  assign red_last = (cnt_q == CntW'(RedSteps - 1));
  assign exp_m2   = OpW'(modulus_q - ModW'(2));

  always_comb begin
    case (step_q)
      STEP_ACC: begin
        mul_x = acc_q;
        mul_y = base_q;
      end
      STEP_SQR: begin
        mul_x = base_q;
        mul_y = base_q;
      end
      default: begin
        mul_x = ared_q;
        mul_y = acc_q;
      end
    endcase
    prod = ProdW'(mul_x) * ProdW'(mul_y);
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------------------
  // sequencer
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    result_d    = result_q;
    req_d       = req_q;
    exp_d       = exp_q;
    base_d      = base_q;
    acc_d       = acc_q;
    ared_d      = ared_q;
    div_d       = div_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          req_d = req_type_i;
          exp_d = operand_b_i;
          div_d = {1'b0, operand_a_i};
          rem_d = '0;
          cnt_d = '0;
          if (modulus_q < ModW'(2) || !(req_type_i == ReqPower ||
              req_type_i == ReqInverse || req_type_i == ReqDivide)) begin
            acc_d   = '0;
            state_d = S_DONE;
          end else begin
            state_d = S_RED_A;
          end
        end
      end

      S_RED_A: begin
        div_d = div_q << 2;
        rem_d = rem_nxt;
        cnt_d = cnt_q + CntW'(1);
        if (red_last) begin
          ared_d = rem_nxt;
          base_d = rem_nxt;
          acc_d  = ModW'(1);
          cnt_d  = '0;
          case (req_q)
            ReqDivide: begin
              // reduce the divisor next; it was parked in the exponent register
              div_d   = {1'b0, exp_q};
              rem_d   = '0;
              state_d = S_RED_B;
            end
            ReqInverse: begin
              exp_d   = exp_m2;
              state_d = S_POW_CHK;
            end
            default: begin
              state_d = S_POW_CHK;
            end
          endcase
        end
      end

      S_RED_B: begin
        div_d = div_q << 2;
        rem_d = rem_nxt;
        cnt_d = cnt_q + CntW'(1);
        if (red_last) begin
          cnt_d = '0;
          if (rem_nxt == '0) begin
            acc_d   = '0;
            state_d = S_DONE;
          end else begin
            base_d  = rem_nxt;
            exp_d   = exp_m2;
            acc_d   = ModW'(1);
            state_d = S_POW_CHK;
          end
        end
      end

      S_POW_CHK: begin
        if (exp_q == '0) begin
          if (req_q == ReqDivide) begin
            step_d  = STEP_FIN;
            state_d = S_MUL;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          step_d  = exp_q[0] ? STEP_ACC : STEP_SQR;
          state_d = S_MUL;
        end
      end

      S_MUL: begin
        div_d   = prod;
        rem_d   = '0;
        cnt_d   = '0;
        state_d = S_RED;
      end

      S_RED: begin
        div_d = div_q << 2;
        rem_d = rem_nxt;
        cnt_d = cnt_q + CntW'(1);
        if (red_last) begin
          cnt_d = '0;
          case (step_q)
            STEP_ACC: begin
              acc_d   = rem_nxt;
              step_d  = STEP_SQR;
              state_d = S_MUL;
            end
            STEP_SQR: begin
              base_d  = rem_nxt;
              exp_d   = exp_q >> 1;
              state_d = S_POW_CHK;
            end
            default: begin
              acc_d   = rem_nxt;
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_DONE: begin
        // hand over once the output register is free or being drained
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          result_d    = acc_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      result_q    <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      result_q    <= result_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    req_q  <= req_d;
    exp_q  <= exp_d;
    base_q <= base_d;
    acc_q  <= acc_d;
    ared_q <= ared_d;
    div_q  <= div_d;
    rem_q  <= rem_d;
    cnt_q  <= cnt_d;
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  // ---------------------------------------------------------------------------
  // checks
  `MPID_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_accept, state_q != S_IDLE,
    "core still idle after taking a request")
  `MPID_ASSERT_NEXT(a_mul_to_red, clk_i, rst_ni, state_q == S_MUL,
    state_q == S_RED && cnt_q == '0, "multiply not followed by a fresh reduction")
  `MPID_ASSERT_NEXT(a_pow_finish, clk_i, rst_ni,
    state_q == S_POW_CHK && exp_q == '0 && req_q != ReqDivide,
    state_q == S_DONE, "exhausted exponent did not finish the request")
  `MPID_ASSERT_NEXT(a_out_drain, clk_i, rst_ni,
    out_valid_q && !out_stall_i && state_q != S_DONE,
    !out_valid_q, "taken result word stayed valid")

endmodule

FILE: tb/modular_power_inverse_divide_core_checker.sv
`timescale 1ns / 1ps
// result checker for the modular power / inverse / divide core: tracks the modulus
// from the config port, predicts every accepted request and compares the result words
// depends on mpid_pkg
module modular_power_inverse_divide_core_checker
  import mpid_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [PAddrW-1:0] paddr,
  input  logic [ModW-1:0]   pwdata,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [ReqW-1:0]   req_type_i,
  input  logic [OpW-1:0]    operand_a_i,
  input  logic [OpW-1:0]    operand_b_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [ModW-1:0]   result_i,
  output int                pending_o,
  output int                fail_count_o
);

  logic [ModW-1:0] modulus_q;
  logic [ModW-1:0] expected_results[$];
  int              errors = 0;

  assign fail_count_o = errors;

  // all values stay below m < 2^32, so every product fits in 64 bits
  function automatic logic [63:0] mod_exp(input logic [63:0] base,
                                          input logic [63:0] exponent,
                                          input logic [63:0] m);
    logic [63:0] acc;
    acc = 64'd1;
    while (exponent != 64'd0) begin
      if (exponent[0]) begin
        acc = (acc * base) % m;
      end
      base     = (base * base) % m;
      exponent = exponent >> 1;
    end
    return acc % m;
  endfunction

  function automatic logic [ModW-1:0] predict_result(input logic [ReqW-1:0] op,
                                                     input logic [OpW-1:0]  a,
                                                     input logic [OpW-1:0]  b,
                                                     input logic [ModW-1:0] m);
    logic [63:0] mm;
    logic [63:0] r;
    logic [63:0] b_red;
    mm = 64'(m);
    r  = 64'd0;
    // modulus 0 or 1 and the undefined code all give 0
    if (mm >= 64'd2) begin
      case (op)
        ReqPower: begin
          r = mod_exp(64'(a) % mm, 64'(b), mm);
        end
        ReqInverse: begin
          r = mod_exp(64'(a) % mm, mm - 64'd2, mm);
        end
        ReqDivide: begin
          b_red = 64'(b) % mm;
          if (b_red != 64'd0) begin
            r = ((64'(a) % mm) * mod_exp(b_red, mm - 64'd2, mm)) % mm;
          end
        end
        default: begin
          r = 64'd0;
        end
      endcase
    end
    return r[ModW-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic [ModW-1:0] want;
    if (!rst_ni) begin
      modulus_q = ModulusReset;
      expected_results.delete();
      pending_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[PAddrW-1:2] == RegModulus) begin
        modulus_q = pwdata;
      end
      if (in_valid_i && !in_stall_i) begin
        expected_results.insert(expected_results.size(),
                                predict_result(req_type_i, operand_a_i, operand_b_i,
                                               modulus_q));
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          errors = errors + 1;
          $display("%0t: result word %0d with no request outstanding", $time, result_i);
        end else begin
          want = expected_results.pop_front();
          if (result_i !== want) begin
            errors = errors + 1;
            $display("%0t: result mismatch, expected %0d actual %0d", $time, want, result_i);
          end
        end
      end
      pending_o <= expected_results.size();
    end
  end

endmodule

FILE: tb/modular_power_inverse_divide_core_tb.sv
`timescale 1ns / 1ps
// top-level testbench for the modular power / inverse / divide core: clock, reset,
// modulus programming, request stimulus, result back-pressure and the verdict
// depends on mpid_pkg, modular_power_inverse_divide_core and its checker
module modular_power_inverse_divide_core_tb;
  import mpid_pkg::*;

  localparam logic [ReqW-1:0] ReqUndefined = 2'd3;
  localparam logic [OpW-1:0]  OpMax        = '1;
  localparam int unsigned     HoldCycles   = 10000;
  localparam int unsigned     QuietLimit   = 60000;
  localparam int unsigned     DrainCycles  = 20;

  logic              clk_i;
  logic              rst_ni    = 1'b0;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [PAddrW-1:0] paddr     = '0;
  logic [ModW-1:0]   pwdata    = '0;
  logic [ModW-1:0]   prdata;
  logic              pready;
  logic              in_valid  = 1'b0;
  logic              in_stall_o;
  logic [ReqW-1:0]   req_type  = '0;
  logic [OpW-1:0]    operand_a = '0;
  logic [OpW-1:0]    operand_b = '0;
  logic              out_valid_o;
  logic              out_stall = 1'b0;
  logic [ModW-1:0]   result_o;

  int              pending;
  int              fail_count;
  logic [ModW-1:0] cur_modulus  = ModulusReset;
  int unsigned     burst_left   = 0;
  bit              hold_request = 1'b0;

  modular_power_inverse_divide_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type),
    .operand_a_i (operand_a),
    .operand_b_i (operand_b),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .result_o    (result_o)
  );

  modular_power_inverse_divide_core_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall_o),
    .req_type_i   (req_type),
    .operand_a_i  (operand_a),
    .operand_b_i  (operand_b),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall),
    .result_i     (result_o),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // mix of small values, masked widths, multiples of m and values near the top
  function automatic logic [OpW-1:0] rand_operand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: v = v & 64'hF;
      1: v = v & ((64'd1 << $urandom_range(1, 40)) - 64'd1);
      2: v = 64'(cur_modulus) * $urandom_range(0, 1000);
      3: v = v | 64'h7FFF_FFFF_FFFF_FF00;
      default: ;
    endcase
    return v[OpW-1:0];
  endfunction

  // exponents are mostly short, since each bit costs a square and maybe a multiply
  function automatic logic [OpW-1:0] rand_exponent();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: ;
      1: v = v & 64'h3;
      default: v = v & ((64'd1 << $urandom_range(1, 24)) - 64'd1);
    endcase
    return v[OpW-1:0];
  endfunction

  // ends a burst now and then with a gap of random length
  task automatic pace();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic offer(input logic [ReqW-1:0] op, input logic [OpW-1:0] a,
                       input logic [OpW-1:0] b);
    req_type  <= op;
    operand_a <= a;
    operand_b <= b;
    in_valid  <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    pace();
  endtask

  task automatic random_items(input int unsigned count);
    logic [ReqW-1:0] op;
    logic [OpW-1:0]  a;
    logic [OpW-1:0]  b;
    int unsigned     pick;
    repeat (count) begin
      pick = $urandom_range(0, 15);
      if (pick < 5) begin
        op = ReqPower;
      end else if (pick < 10) begin
        op = ReqInverse;
      end else if (pick < 15) begin
        op = ReqDivide;
      end else begin
        op = ReqUndefined;
      end
      a = rand_operand();
      b = (op == ReqPower) ? rand_exponent() : rand_operand();
      offer(op, a, b);
    end
  endtask

  // every request yields one word, so an empty queue means the core is idle
  task automatic drain();
    if (in_valid) begin
      in_valid <= 1'b0;
    end
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_modulus(input logic [ModW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {RegModulus, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_modulus = value;
  endtask

  task automatic next_modulus(input logic [ModW-1:0] value);
    drain();
    write_modulus(value);
  endtask

  initial begin : receiver
    int unsigned pct;
    int unsigned left;
    pct  = 0;
    left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        // long hold-off so the core fills up and stalls its input
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        out_stall <= 1'b0;
      end else begin
        if (left == 0) begin
          left = $urandom_range(32, 256);
          case ($urandom_range(0, 2))
            0: pct = 0;
            1: pct = 25;
            default: pct = 75;
          endcase
        end
        left--;
        out_stall <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no word moved for %0d cycles", $time, QuietLimit);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset modulus: operand extremes, zero exponent, multiples of m, undefined code
    offer(ReqPower, '0, '0);
    offer(ReqPower, OpMax, OpMax);
    offer(ReqPower, 63'd2, 63'd10);
    offer(ReqPower, '0, 63'd5);
    offer(ReqPower, 63'(cur_modulus) * 3, 63'd7);
    offer(ReqInverse, '0, OpMax);
    offer(ReqInverse, OpMax, '0);
    offer(ReqInverse, 63'(cur_modulus), 63'd1);
    offer(ReqDivide, OpMax, OpMax);
    offer(ReqDivide, 63'd5, '0);
    offer(ReqDivide, 63'd7, 63'(cur_modulus) * 2);
    offer(ReqUndefined, OpMax, OpMax);
    random_items(12);

    // modulus zero gives 0 for everything
    next_modulus(32'd0);
    offer(ReqPower, 63'd5, '0);
    offer(ReqDivide, 63'd4, 63'd3);
    random_items(6);

    // modulus one: even a zero exponent reduces to 0
    next_modulus(32'd1);
    offer(ReqPower, 63'd9, '0);
    offer(ReqInverse, OpMax, OpMax);
    random_items(6);

    // modulus two: the inverse exponent m-2 is 0, so even an even base gives 1
    next_modulus(32'd2);
    offer(ReqInverse, 63'd4, '0);
    offer(ReqInverse, 63'd3, '0);
    offer(ReqDivide, 63'd1, 63'd2);
    random_items(8);

    next_modulus(32'd3);
    random_items(8);

    next_modulus(32'd97);
    hold_request = 1'b1;
    random_items(20);

    next_modulus(32'd65521);
    random_items(14);

    next_modulus(32'd2147483647);
    random_items(14);

    next_modulus(32'd3037000499);
    offer(ReqPower, OpMax, OpMax);
    random_items(12);

    // above the meaningful range, used as is
    next_modulus(32'hFFFF_FFFF);
    offer(ReqInverse, OpMax, '0);
    offer(ReqDivide, OpMax, 63'h0_FFFF_FFFF);
    random_items(10);

    next_modulus($urandom);
    random_items(10);

    drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
